// ===== rtl/core/sgdm_pkg.sv =====
`default_nettype none

package sgdm_pkg;

    localparam int INDEX_W  = 12;
    localparam int VALUE_W  = 32;
    localparam int COEF_W   = 17;
    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 32;
    localparam int IDX_SPAN = 2 ** INDEX_W;

    localparam int PROD_W = 50;
    localparam int SUM_W  = 51;
    localparam int RND_W  = 35;
    localparam int WIDE_W = 36;

    localparam logic [2:0] REG_LEARNING_RATE = 3'd0;
    localparam logic [2:0] REG_MOMENTUM      = 3'd1;
    localparam logic [2:0] REG_DAMPENING     = 3'd2;
    localparam logic [2:0] REG_WEIGHT_DECAY  = 3'd3;
    localparam logic [2:0] REG_NESTEROV      = 3'd4;

    typedef logic signed [VALUE_W-1:0] value_t;
    typedef logic        [COEF_W-1:0]  coef_t;
    typedef logic signed [PROD_W-1:0]  prod_t;
    typedef logic signed [SUM_W-1:0]   sum_t;
    typedef logic signed [RND_W-1:0]   rnd_t;
    typedef logic signed [WIDE_W-1:0]  wide_t;

    typedef struct packed {
        logic   flag;
        value_t val;
    } sat_t;

    // Round Q.32 to Q.16, halves toward plus infinity
    function automatic rnd_t rnd_q16(input sum_t p);
        sum_t q;
        q = p + SUM_W'(32768);
        return q[SUM_W-1:16];
    endfunction

    function automatic sat_t sat_q32(input wide_t v);
        sat_t r;
        r.flag = !((&v[WIDE_W-1:VALUE_W-1]) || (~|v[WIDE_W-1:VALUE_W-1]));
        if (r.flag)
        begin
            r.val = v[WIDE_W-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
        else
        begin
            r.val = v[VALUE_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/sgd_momentum_weight_update.sv =====
`default_nettype none

// SGD weight update with momentum and Nesterov option, Q16.16 values and Q1.16
// coefficients. One item is taken per clock while in_stall is low; a result
// leaves through an output register backed by a one-entry skid, so the input keeps
// flowing while one result waits, and a second waiting result stalls the pipeline.
// The momentum buffer is a single-port-write, single-port-read RAM written 4 stages
// after the read: while momentum is nonzero, an item whose index matches an item
// still in stages s1 to s4 waits at the input stage until that write lands. The
// buffer has no reset; an entry must be written in the first optimizer step before
// a later step reads it.
module sgd_momentum_weight_update
    import sgdm_pkg::*;
#(
    parameter int NUM_ELEMENTS = 4096
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [ADDR_W-1:0]   paddr,
    input  wire logic [DATA_W-1:0]   pwdata,
    output logic      [DATA_W-1:0]   prdata,
    output logic                     pready,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic [INDEX_W-1:0]  element_index,
    input  wire logic signed [VALUE_W-1:0] weight_value,
    input  wire logic signed [VALUE_W-1:0] gradient_value,
    input  wire logic                last_of_step,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic signed [VALUE_W-1:0] new_weight,
    output logic                     saturated
);

    localparam int IDX_W = (NUM_ELEMENTS > 1) ? $clog2(NUM_ELEMENTS) : 1;

    // configuration
    coef_t learning_rate_reg;
    coef_t momentum_coef_reg;
    coef_t dampening_coef_reg;
    coef_t weight_decay_coef_reg;
    logic  nesterov_enable_reg;
    logic  cfg_write;
    logic  momentum_nz;

    assign pready      = 1'b1;
    assign cfg_write   = psel && penable && pwrite;
    assign momentum_nz = (momentum_coef_reg != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            learning_rate_reg     <= '0;
            momentum_coef_reg     <= '0;
            dampening_coef_reg    <= '0;
            weight_decay_coef_reg <= '0;
            nesterov_enable_reg   <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (paddr[4:2])
                REG_LEARNING_RATE: learning_rate_reg     <= pwdata[COEF_W-1:0];
                REG_MOMENTUM:      momentum_coef_reg     <= pwdata[COEF_W-1:0];
                REG_DAMPENING:     dampening_coef_reg    <= pwdata[COEF_W-1:0];
                REG_WEIGHT_DECAY:  weight_decay_coef_reg <= pwdata[COEF_W-1:0];
                REG_NESTEROV:      nesterov_enable_reg   <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[4:2])
            REG_LEARNING_RATE: prdata = DATA_W'(learning_rate_reg);
            REG_MOMENTUM:      prdata = DATA_W'(momentum_coef_reg);
            REG_DAMPENING:     prdata = DATA_W'(dampening_coef_reg);
            REG_WEIGHT_DECAY:  prdata = DATA_W'(weight_decay_coef_reg);
            REG_NESTEROV:      prdata = DATA_W'(nesterov_enable_reg);
            default:           prdata = '0;
        endcase
    end

    // pipeline control
    logic en;
    logic in_accept;
    logic hazard;
    logic a_go;
    logic first_step_done_reg;

    logic a_valid_reg;
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic s5_valid_reg, s6_valid_reg, s7_valid_reg;
    logic out_valid_reg, skid_valid_reg;

    // input stage
    logic [INDEX_W-1:0] a_index_reg;
    logic [IDX_W-1:0]   a_idx;
    value_t             a_weight_reg;
    value_t             a_grad_reg;
    logic               a_first_reg;

    generate
        if (NUM_ELEMENTS >= IDX_SPAN)
        begin : g_idx_wide
            assign a_idx = IDX_W'(a_index_reg);
        end
        else
        begin : g_idx_mod
            localparam logic [24:0] RECIP = 25'((2 ** 24 + NUM_ELEMENTS - 1) / NUM_ELEMENTS);
            localparam logic [12:0] NUM_C = 13'(NUM_ELEMENTS);
            logic [36:0] recip_prod;
            logic [12:0] quo_reg;
            logic [25:0] quo_num;
            logic [INDEX_W-1:0] rem;

            assign recip_prod = 37'(element_index) * 37'(RECIP);
            assign quo_num    = 26'(quo_reg) * 26'(NUM_C);
            assign rem        = a_index_reg - quo_num[INDEX_W-1:0];
            assign a_idx      = IDX_W'(rem);

            always_ff @(posedge clk)
            begin
                if (in_accept)
                begin
                    quo_reg <= recip_prod[36:24];
                end
            end
        end
    endgenerate

    // stage registers
    logic [IDX_W-1:0] s1_idx_reg, s2_idx_reg, s3_idx_reg, s4_idx_reg;
    value_t s1_weight_reg, s2_weight_reg, s3_weight_reg, s4_weight_reg;
    value_t s5_weight_reg, s6_weight_reg, s7_weight_reg;
    value_t s1_grad_reg;
    value_t s2_grad_reg, s3_grad_reg, s4_grad_reg, s5_grad_reg;
    logic   s1_first_reg, s2_first_reg, s3_first_reg;
    logic   s2_flag_reg, s3_flag_reg, s4_flag_reg, s5_flag_reg, s6_flag_reg, s7_flag_reg;
    prod_t  s1_decay_prod_reg;
    value_t s2_prev_reg;
    prod_t  s3_mom_prod_reg, s3_keep_prod_reg;
    value_t s4_buf_reg, s5_buf_reg;
    prod_t  s5_nest_prod_reg;
    value_t s6_eff_reg;
    prod_t  s7_lr_prod_reg;

    logic [VALUE_W-1:0] ram_rdata;

    // combinational stage results
    prod_t              decay_prod_next;
    sat_t               grad_next;
    prod_t              mom_prod_next, keep_prod_next;
    logic signed [17:0] keep_coef;
    sat_t               buf_sat;
    value_t             buf_next;
    logic               buf_flag_next;
    prod_t              nest_prod_next;
    sat_t               nest_sat;
    value_t             eff_next;
    logic               eff_flag_next;
    prod_t              lr_prod_next;
    sat_t               res_next;
    logic               res_flag_next;

    assign en        = !skid_valid_reg;
    assign in_accept = in_valid && !in_stall;
    assign hazard    = momentum_nz && (
                           (s1_valid_reg && (s1_idx_reg == a_idx)) ||
                           (s2_valid_reg && (s2_idx_reg == a_idx)) ||
                           (s3_valid_reg && (s3_idx_reg == a_idx)) ||
                           (s4_valid_reg && (s4_idx_reg == a_idx)));
    assign a_go      = en && a_valid_reg && !hazard;
    assign in_stall  = a_valid_reg && !a_go;

    assign decay_prod_next = $signed({1'b0, weight_decay_coef_reg}) * a_weight_reg;
    assign grad_next       = sat_q32(WIDE_W'(s1_grad_reg) +
                                     WIDE_W'(rnd_q16(SUM_W'(s1_decay_prod_reg))));

    assign keep_coef      = $signed(18'h1_0000) - $signed({1'b0, dampening_coef_reg});
    assign mom_prod_next  = $signed({1'b0, momentum_coef_reg}) * s2_prev_reg;
    assign keep_prod_next = keep_coef * s2_grad_reg;

    assign buf_sat       = sat_q32(WIDE_W'(rnd_q16(SUM_W'(s3_mom_prod_reg) +
                                                    SUM_W'(s3_keep_prod_reg))));
    assign buf_next      = s3_first_reg ? s3_grad_reg : buf_sat.val;
    assign buf_flag_next = momentum_nz && !s3_first_reg && buf_sat.flag;

    assign nest_prod_next = $signed({1'b0, momentum_coef_reg}) * s4_buf_reg;
    assign nest_sat       = sat_q32(WIDE_W'(s5_grad_reg) +
                                    WIDE_W'(rnd_q16(SUM_W'(s5_nest_prod_reg))));

    always_comb
    begin
        eff_next      = s5_grad_reg;
        eff_flag_next = 1'b0;
        if (momentum_nz)
        begin
            if (nesterov_enable_reg)
            begin
                eff_next      = nest_sat.val;
                eff_flag_next = nest_sat.flag;
            end
            else
            begin
                eff_next = s5_buf_reg;
            end
        end
    end

    assign lr_prod_next  = $signed({1'b0, learning_rate_reg}) * s6_eff_reg;
    assign res_next      = sat_q32(WIDE_W'(s7_weight_reg) -
                                   WIDE_W'(rnd_q16(SUM_W'(s7_lr_prod_reg))));
    assign res_flag_next = s7_flag_reg || res_next.flag;

    sgdm_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (NUM_ELEMENTS)
    ) u_buffer (
        .clk   (clk),
        .we    (en && s4_valid_reg && momentum_nz),
        .waddr (s4_idx_reg),
        .wdata (s4_buf_reg),
        .re    (a_go),
        .raddr (a_idx),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_step_done_reg <= 1'b0;
            a_valid_reg         <= 1'b0;
            s1_valid_reg        <= 1'b0;
            s2_valid_reg        <= 1'b0;
            s3_valid_reg        <= 1'b0;
            s4_valid_reg        <= 1'b0;
            s5_valid_reg        <= 1'b0;
            s6_valid_reg        <= 1'b0;
            s7_valid_reg        <= 1'b0;
        end
        else
        begin
            if (in_accept && last_of_step)
            begin
                first_step_done_reg <= 1'b1;
            end
            if (in_accept)
            begin
                a_valid_reg <= 1'b1;
            end
            else if (a_go)
            begin
                a_valid_reg <= 1'b0;
            end
            if (en)
            begin
                s1_valid_reg <= a_go;
                s2_valid_reg <= s1_valid_reg;
                s3_valid_reg <= s2_valid_reg;
                s4_valid_reg <= s3_valid_reg;
                s5_valid_reg <= s4_valid_reg;
                s6_valid_reg <= s5_valid_reg;
                s7_valid_reg <= s6_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            a_index_reg  <= element_index;
            a_weight_reg <= weight_value;
            a_grad_reg   <= gradient_value;
            a_first_reg  <= !first_step_done_reg;
        end
        if (en)
        begin
            s1_idx_reg        <= a_idx;
            s1_weight_reg     <= a_weight_reg;
            s1_grad_reg       <= a_grad_reg;
            s1_first_reg      <= a_first_reg;
            s1_decay_prod_reg <= decay_prod_next;

            s2_idx_reg    <= s1_idx_reg;
            s2_weight_reg <= s1_weight_reg;
            s2_grad_reg   <= grad_next.val;
            s2_flag_reg   <= grad_next.flag;
            s2_first_reg  <= s1_first_reg;
            s2_prev_reg   <= ram_rdata;

            s3_idx_reg       <= s2_idx_reg;
            s3_weight_reg    <= s2_weight_reg;
            s3_grad_reg      <= s2_grad_reg;
            s3_flag_reg      <= s2_flag_reg;
            s3_first_reg     <= s2_first_reg;
            s3_mom_prod_reg  <= mom_prod_next;
            s3_keep_prod_reg <= keep_prod_next;

            s4_idx_reg    <= s3_idx_reg;
            s4_weight_reg <= s3_weight_reg;
            s4_grad_reg   <= s3_grad_reg;
            s4_flag_reg   <= s3_flag_reg || buf_flag_next;
            s4_buf_reg    <= buf_next;

            s5_weight_reg    <= s4_weight_reg;
            s5_grad_reg      <= s4_grad_reg;
            s5_flag_reg      <= s4_flag_reg;
            s5_buf_reg       <= s4_buf_reg;
            s5_nest_prod_reg <= nest_prod_next;

            s6_weight_reg <= s5_weight_reg;
            s6_flag_reg   <= s5_flag_reg || eff_flag_next;
            s6_eff_reg    <= eff_next;

            s7_weight_reg  <= s6_weight_reg;
            s7_flag_reg    <= s6_flag_reg;
            s7_lr_prod_reg <= lr_prod_next;
        end
    end

    // output register with one-entry skid
    value_t out_weight_reg, skid_weight_reg;
    logic   out_sat_reg, skid_sat_reg;
    logic   out_free;
    logic   last_move;

    assign out_free  = !out_valid_reg || !out_stall;
    assign last_move = en && s7_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= last_move;
            end
        end
        else if (last_move)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_weight_reg <= skid_weight_reg;
                out_sat_reg    <= skid_sat_reg;
            end
            else if (last_move)
            begin
                out_weight_reg <= res_next.val;
                out_sat_reg    <= res_flag_next;
            end
        end
        else if (last_move)
        begin
            skid_weight_reg <= res_next.val;
            skid_sat_reg    <= res_flag_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign new_weight = out_weight_reg;
    assign saturated  = out_sat_reg;

endmodule

`default_nettype wire

// ===== rtl/core/sgdm_ram.sv =====
`default_nettype none

module sgdm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  wire logic                                   clk,
    input  wire logic                                   we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                       wdata,
    input  wire logic                                   re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/sgdm_checker.sv =====
`default_nettype none

module sgdm_checker
    import sgdm_pkg::*;
(
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                in_valid,
    input wire logic                in_stall,
    input wire logic                out_valid,
    input wire logic                out_stall,
    input wire logic signed [VALUE_W-1:0] new_weight,
    input wire logic                saturated
);

    // input stage, seven pipeline stages, output register, skid
    localparam logic [3:0] MAX_IN_FLIGHT = 4'd10;

    logic       in_xfer;
    logic       out_xfer;
    logic [3:0] in_flight_reg;

    assign in_xfer  = in_valid && !in_stall;
    assign out_xfer = out_valid && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_flight_reg <= '0;
        end
        else if (in_xfer && !out_xfer)
        begin
            in_flight_reg <= in_flight_reg + 4'd1;
        end
        else if (out_xfer && !in_xfer)
        begin
            in_flight_reg <= in_flight_reg - 4'd1;
        end
    end

    a_no_invented_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_xfer |-> (in_flight_reg != 4'd0))
        else $error("result delivered with no transaction outstanding");

    a_in_flight_bound: assert property (@(posedge clk) disable iff (!rst_n)
        in_flight_reg <= MAX_IN_FLIGHT)
        else $error("more transactions in flight than the pipeline holds");

    a_idle_takes_input: assert property (@(posedge clk) disable iff (!rst_n)
        (in_flight_reg == 4'd0) |-> !in_stall)
        else $error("input stalled while block is empty");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(new_weight) && $stable(saturated)))
        else $error("stalled result changed");

    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("result valid during reset");

endmodule

bind sgd_momentum_weight_update sgdm_checker u_sgdm_checker (.*);

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;
    import sgdm_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 16;
    localparam int ERROR_PRINTS = 50;

    localparam logic [2:0] REG_SPARE_FIRST = 3'd5;
    localparam logic [2:0] REG_SPARE_LAST  = 3'd7;

    localparam value_t VALUE_MAX = 32'sh7FFF_FFFF;
    localparam value_t VALUE_MIN = 32'sh8000_0000;
    localparam coef_t  COEF_ONE          = 17'd65536;
    localparam coef_t  COEF_ONE_AND_HALF = 17'd98304;
    localparam coef_t  COEF_MAX          = 17'd131071;

    typedef struct {
        value_t weight;
        logic   sat;
    } update_t;

    logic                  clk            = 1'b0;
    logic                  rst_n          = 1'b0;
    logic                  psel           = 1'b0;
    logic                  penable        = 1'b0;
    logic                  pwrite         = 1'b0;
    logic [ADDR_W-1:0]     paddr          = '0;
    logic [DATA_W-1:0]     pwdata         = '0;
    logic [DATA_W-1:0]     prdata;
    logic                  pready;
    logic                  in_valid       = 1'b0;
    logic                  in_stall;
    logic [INDEX_W-1:0]    element_index  = '0;
    value_t                weight_value   = '0;
    value_t                gradient_value = '0;
    logic                  last_of_step   = 1'b0;
    logic                  out_valid;
    logic                  out_stall      = 1'b0;
    value_t                new_weight;
    logic                  saturated;

    coef_t  lr_cfg       = '0;
    coef_t  mom_cfg      = '0;
    coef_t  damp_cfg     = '0;
    coef_t  decay_cfg    = '0;
    logic   nesterov_cfg = 1'b0;

    value_t             velocity_mem [IDX_SPAN];
    bit                 entry_primed [IDX_SPAN];
    logic [INDEX_W-1:0] primed_indices[$];
    bit                 step_one_over = 1'b0;
    logic [INDEX_W-1:0] prev_index    = '0;

    update_t expected_updates[$];
    int      error_count = 0;
    int      stall_left  = 0;
    bit      calm        = 1'b0;

    sgd_momentum_weight_update #(.NUM_ELEMENTS(IDX_SPAN)) u_top (.*);

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("sgd_momentum_weight_update test failed");
        $finish;
    end

    task automatic report_error(input string msg);
        if (error_count < ERROR_PRINTS)
        begin
            $display("ERROR at %0t: %s", $time, msg);
        end
        error_count++;
    endtask

    function automatic longint round_q16(input longint p);
        return (p + 64'sd32768) >>> 16;
    endfunction

    function automatic longint clamp_q32(input longint v, inout logic flag);
        if (v > longint'(VALUE_MAX))
        begin
            flag = 1'b1;
            return longint'(VALUE_MAX);
        end
        if (v < longint'(VALUE_MIN))
        begin
            flag = 1'b1;
            return longint'(VALUE_MIN);
        end
        return v;
    endfunction

    function automatic update_t predict_update(input logic [INDEX_W-1:0] idx,
                                               input value_t w, input value_t g,
                                               input logic last);
        update_t res;
        logic    clipped;
        longint  wv;
        longint  gv;
        longint  bufv;
        longint  effv;
        longint  keep;
        clipped = 1'b0;
        wv = longint'(w);
        gv = longint'(g);
        if (decay_cfg != '0)
        begin
            gv = clamp_q32(gv + round_q16(longint'(decay_cfg) * wv), clipped);
        end
        effv = gv;
        if (mom_cfg != '0)
        begin
            if (!step_one_over)
            begin
                bufv = gv;
            end
            else
            begin
                keep = 64'sd65536 - longint'(damp_cfg);
                bufv = clamp_q32(round_q16(longint'(mom_cfg) * longint'(velocity_mem[idx])
                                           + keep * gv), clipped);
            end
            velocity_mem[idx] = value_t'(bufv);
            if (!entry_primed[idx])
            begin
                entry_primed[idx] = 1'b1;
                primed_indices.push_back(idx);
            end
            if (nesterov_cfg)
            begin
                effv = clamp_q32(gv + round_q16(longint'(mom_cfg) * bufv), clipped);
            end
            else
            begin
                effv = bufv;
            end
        end
        res.weight = value_t'(clamp_q32(wv - round_q16(longint'(lr_cfg) * effv), clipped));
        res.sat = clipped;
        if (last)
        begin
            step_one_over = 1'b1;
        end
        return res;
    endfunction

    function automatic value_t random_value();
        case ($urandom_range(0, 4))
            0: return value_t'($urandom);
            1: return value_t'(int'($urandom_range(0, 1 << 20)) - (1 << 19));
            2: return value_t'(int'($urandom_range(0, 1 << 26)) - (1 << 25));
            3:
            begin
                case ($urandom_range(0, 3))
                    0: return VALUE_MAX;
                    1: return VALUE_MIN;
                    2: return '0;
                    default: return -32'sd1;
                endcase
            end
            default: return value_t'(int'($urandom_range(0, 1 << 17)) - (1 << 16));
        endcase
    endfunction

    function automatic coef_t random_coef();
        case ($urandom_range(0, 4))
            0: return '0;
            1: return COEF_ONE;
            2: return COEF_MAX;
            default: return coef_t'($urandom_range(0, COEF_MAX));
        endcase
    endfunction

    // Never read an unwritten velocity entry once the first step is over
    function automatic logic [INDEX_W-1:0] pick_index();
        if (mom_cfg != '0 && step_one_over)
        begin
            if ($urandom_range(0, 7) == 0 && entry_primed[prev_index])
            begin
                return prev_index;
            end
            return primed_indices[$urandom_range(0, primed_indices.size() - 1)];
        end
        if ($urandom_range(0, 7) == 0)
        begin
            return prev_index;
        end
        return INDEX_W'($urandom_range(0, IDX_SPAN - 1));
    endfunction

    task automatic write_reg(input logic [2:0] reg_idx, input logic [DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({reg_idx, 2'b00});
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (reg_idx)
            REG_LEARNING_RATE: lr_cfg       = coef_t'(data);
            REG_MOMENTUM:      mom_cfg      = coef_t'(data);
            REG_DAMPENING:     damp_cfg     = coef_t'(data);
            REG_WEIGHT_DECAY:  decay_cfg    = coef_t'(data);
            REG_NESTEROV:      nesterov_cfg = data[0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic check_reg(input logic [2:0] reg_idx);
        logic [DATA_W-1:0] want;
        case (reg_idx)
            REG_LEARNING_RATE: want = DATA_W'(lr_cfg);
            REG_MOMENTUM:      want = DATA_W'(mom_cfg);
            REG_DAMPENING:     want = DATA_W'(damp_cfg);
            REG_WEIGHT_DECAY:  want = DATA_W'(decay_cfg);
            REG_NESTEROV:      want = DATA_W'(nesterov_cfg);
            default:           want = '0;
        endcase
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_W'({reg_idx, 2'b00});
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        if (prdata !== want)
        begin
            report_error($sformatf("register %0d read 0x%0h, expected 0x%0h",
                                   reg_idx, prdata, want));
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic check_all_regs();
        for (int r = REG_LEARNING_RATE; r <= REG_NESTEROV; r++)
        begin
            check_reg(3'(r));
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (expected_updates.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_config(input coef_t lr, input coef_t mom, input coef_t damp,
                              input coef_t decay, input logic nest);
        drain();
        write_reg(REG_LEARNING_RATE, DATA_W'(lr));
        write_reg(REG_MOMENTUM, DATA_W'(mom));
        write_reg(REG_DAMPENING, DATA_W'(damp));
        write_reg(REG_WEIGHT_DECAY, DATA_W'(decay));
        write_reg(REG_NESTEROV, DATA_W'(nest));
        check_all_regs();
    endtask

    task automatic send_update(input logic [INDEX_W-1:0] idx, input value_t w,
                               input value_t g, input logic last);
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        in_valid       <= 1'b1;
        element_index  <= idx;
        weight_value   <= w;
        gradient_value <= g;
        last_of_step   <= last;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        expected_updates.push_back(predict_update(idx, w, g, last));
        prev_index = idx;
    endtask

    task automatic send_random();
        send_update(pick_index(), random_value(), random_value(), $urandom_range(0, 15) == 0);
    endtask

    task automatic check_update();
        update_t want;
        if (expected_updates.size() == 0)
        begin
            report_error($sformatf("unexpected result new_weight=0x%0h", new_weight));
        end
        else
        begin
            want = expected_updates.pop_front();
            if (new_weight !== want.weight)
            begin
                report_error($sformatf("new_weight 0x%0h, expected 0x%0h",
                                       new_weight, want.weight));
            end
            if (saturated !== want.sat)
            begin
                report_error($sformatf("saturated %b, expected %b", saturated, want.sat));
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall == 1'b0)
        begin
            check_update();
        end
        if (stall_left > 0)
        begin
            stall_left--;
            if (stall_left == 0)
            begin
                out_stall <= 1'b0;
            end
        end
        else if (!calm && rst_n && $urandom_range(0, 5) == 0)
        begin
            out_stall <= 1'b1;
            stall_left = $urandom_range(1, 8);
        end
    end

    task automatic test_register_access();
        check_all_regs();
        write_reg(REG_LEARNING_RATE, DATA_W'(COEF_MAX));
        write_reg(REG_MOMENTUM, DATA_W'(COEF_ONE));
        write_reg(REG_DAMPENING, 32'hFFFE_0001);
        write_reg(REG_WEIGHT_DECAY, DATA_W'(COEF_MAX));
        write_reg(REG_NESTEROV, 32'hFFFF_FFFF);
        check_all_regs();
        for (int r = REG_SPARE_FIRST; r <= REG_SPARE_LAST; r++)
        begin
            write_reg(3'(r), $urandom);
        end
        check_all_regs();
    endtask

    // Momentum stays off, so no velocity entry is touched
    task automatic test_plain_extremes();
        set_config('0, '0, '0, '0, 1'b0);
        send_update('0, VALUE_MAX, VALUE_MIN, 1'b0);
        send_update('1, VALUE_MIN, VALUE_MAX, 1'b0);
        set_config(COEF_ONE, '0, '0, '0, 1'b0);
        send_update('0, VALUE_MAX, VALUE_MIN, 1'b0);
        send_update('1, VALUE_MIN, VALUE_MAX, 1'b0);
        send_update(12'hAAA, 32'sh0001_8000, 32'sh0000_8000, 1'b0);
        set_config(COEF_MAX, '0, '0, COEF_MAX, 1'b0);
        send_update(12'h555, VALUE_MAX, VALUE_MAX, 1'b0);
        send_update('0, VALUE_MIN, '0, 1'b0);
    endtask

    task automatic test_first_step();
        set_config(17'h08000, 17'h0E666, 17'h01000, 17'h00100, 1'b0);
        send_update('0, VALUE_MAX, VALUE_MIN, 1'b0);
        send_update('1, VALUE_MIN, VALUE_MAX, 1'b0);
        send_update(12'hAAA, random_value(), random_value(), 1'b0);
        send_update(12'h555, random_value(), random_value(), 1'b0);
        set_config(17'h08000, 17'h0E666, 17'h01000, 17'h00100, 1'b1);
        send_update('0, 32'sh0002_0000, 32'sh0000_4000, 1'b0);
        send_update('1, -32'sh0002_0000, -32'sh0000_4000, 1'b0);
        set_config(random_coef(), 17'h0E666, random_coef(), random_coef(), 1'($urandom));
        repeat (80)
        begin
            send_update(INDEX_W'($urandom), random_value(), random_value(), 1'b0);
        end
        send_update(INDEX_W'($urandom), random_value(), random_value(), 1'b1);
    endtask

    task automatic test_later_step();
        logic [INDEX_W-1:0] fresh;
        set_config(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, 1'b1);
        send_update('0, VALUE_MAX, VALUE_MAX, 1'b0);
        send_update('1, VALUE_MIN, VALUE_MIN, 1'b0);
        set_config(COEF_ONE, COEF_ONE, COEF_ONE_AND_HALF, '0, 1'b0);
        send_update(12'hAAA, 32'sh0000_1000, 32'sh0003_0000, 1'b0);
        send_update(12'h555, VALUE_MIN, VALUE_MAX, 1'b0);
        set_config(COEF_ONE, '0, '0, '0, 1'b0);
        fresh = '0;
        while (entry_primed[fresh]) fresh++;
        send_update(fresh, random_value(), random_value(), 1'b0);
        send_update('0, 32'sh0001_0000, VALUE_MIN, 1'b0);
        // index 0 must still hold its velocity from before the zero-momentum item
        set_config(COEF_ONE, 17'h08000, '0, '0, 1'b0);
        send_update('0, 32'sh0001_0000, 32'sh0000_2000, 1'b0);
    endtask

    task automatic test_random_phases();
        repeat (6)
        begin
            set_config(random_coef(), random_coef(), random_coef(), random_coef(),
                       1'($urandom));
            repeat (60) send_random();
        end
    endtask

    task automatic test_steady_tail();
        calm = 1'b1;
        set_config(random_coef(), random_coef(), random_coef(), random_coef(), 1'($urandom));
        repeat (60) send_random();
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_register_access();
        test_plain_extremes();
        test_first_step();
        test_later_step();
        test_random_phases();
        test_steady_tail();
        drain();
        if (error_count == 0)
        begin
            $display("sgd_momentum_weight_update test passed");
        end
        else
        begin
            $display("sgd_momentum_weight_update test failed");
        end
        $finish;
    end

endmodule
